// File: sv/stle_pkg.sv
// Package with the constants and types of the sorted timer list engine.
`timescale 1ns / 1ps
package stle_pkg;
  localparam int SLOTS = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int MAX_EVENTS = 16;
  localparam int EV_W = $clog2(MAX_EVENTS + 1);
  localparam int DL_W = 50;
  localparam int NOW_W = 48;
  localparam logic [9:0] US_PER_MS = 10'd1000;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_START  = 3'd1;
  localparam logic [2:0] OP_STOP   = 3'd2;
  localparam logic [2:0] OP_FREE   = 3'd3;
  localparam logic [2:0] OP_UPDATE = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_IDLE      = 2'd3;

  localparam logic KIND_REPLY  = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    logic [2:0]       op;
    logic [31:0]      handle;
    logic [31:0]      tmo_ms;
    logic             periodic;
    logic             run_at_once;
    logic [NOW_W-1:0] now_us;
  } item_t;
endpackage

// File: sv/sorted_timer_list_engine.sv
// Top level of the sorted timer list engine: slot table, scan sequencer and result register.
`timescale 1ns / 1ps
// A command takes one transaction in and gives one reply; op codes 6 and 7 give none. A tick
// gives one expiry per due timer, up to sixteen. The block holds one item at a time. A command
// is accepted in S_IDLE, scans the sixteen slots one per cycle through a single shared compare
// unit, multiplies the timeout by 1000 in S_MUL and updates the slot while loading the reply in
// S_EXEC. A tick runs one such scan, multiply and update round for each event it fires plus one
// final round that finds nothing; with sixteen events the final round is replaced by the S_PUSH
// state that sends the last expiry. An expiry is held back one round so the final one can
// carry the last flag. The update state S_EXEC and the state S_PUSH wait while the output register
// still holds a result that has not been taken.
module sorted_timer_list_engine import stle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[2:0], handle[34:3], timeout[66:35], periodic[67], run_at_once[68],
  // now_us[116:69], zero fill to 120 bits.
  input  logic [119:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // result_handle[31:0], status[33:32], zero fill to 40 bits.
  output logic [39:0]  out_tdata,
  // kind.
  output logic         out_tuser,
  output logic         out_tlast
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_PUSH = 3'd4;

  logic [2:0] state_r, state_nxt;
  item_t item_r;
  logic [SLOTS-1:0] used_r, running_r, fired_r;
  logic [31:0] handle_a_r [SLOTS];
  logic [31:0] timeout_a_r [SLOTS];
  logic [SLOTS-1:0] periodic_r, immediate_r;
  logic [DL_W-1:0] deadline_a_r [SLOTS];
  logic [31:0] order_a_r [SLOTS];
  logic [31:0] last_handle_r, order_counter_r;
  logic [SLOT_W-1:0] idx_r;
  logic found_r;
  logic [SLOT_W-1:0] best_r;
  logic [DL_W-1:0] best_dl_r;
  logic [31:0] best_ord_r;
  logic [EV_W-1:0] nev_r;
  logic [DL_W-1:0] delay_r;
  logic pend_v_r;
  logic [31:0] pend_hnd_r;
  logic ov_r, okind_r, olast_r;
  logic [31:0] ohandle_r;
  logic [1:0] ostatus_r;
  logic [31:0] next_handle;
  logic [1:0] reply_status;
  logic cand, better, out_free, apply;
  logic emit, e_kind, e_last;
  logic [31:0] e_handle;
  logic [1:0] e_status;

  assign in_tready = (state_r == S_IDLE);
  assign out_free = !ov_r || out_tready;
  assign apply = (state_r == S_EXEC) && out_free;
  assign out_tvalid = ov_r;
  assign out_tdata = {6'd0, ostatus_r, ohandle_r};
  assign out_tuser = okind_r;
  assign out_tlast = olast_r;
  assign next_handle = (last_handle_r == 32'hFFFF_FFFF) ? 32'd1 : last_handle_r + 32'd1;

  always_comb begin
    cand = 1'b0;
    better = !found_r;
    if (item_r.op == OP_TICK) begin
      cand = used_r[idx_r] && running_r[idx_r] && !fired_r[idx_r] &&
             (deadline_a_r[idx_r] <= {2'b00, item_r.now_us});
      better = !found_r || (deadline_a_r[idx_r] < best_dl_r) ||
               ((deadline_a_r[idx_r] == best_dl_r) && (order_a_r[idx_r] < best_ord_r));
    end else if (item_r.op == OP_ALLOC) begin
      cand = !used_r[idx_r];
    end else begin
      cand = used_r[idx_r] && (handle_a_r[idx_r] == item_r.handle);
    end
  end

  always_comb begin
    reply_status = ST_OK;
    if (!found_r) begin
      reply_status = ST_NOT_FOUND;
    end else if (item_r.op == OP_STOP) begin
      if (!running_r[best_r]) reply_status = ST_IDLE;
    end else if (running_r[best_r]) begin
      reply_status = ST_NOT_FOUND;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_SCAN;
      S_SCAN: if (idx_r == SLOT_W'(SLOTS - 1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_EXEC;
      S_EXEC: begin
        if (out_free) begin
          if (item_r.op == OP_TICK && found_r)
            state_nxt = (nev_r == EV_W'(MAX_EVENTS - 1)) ? S_PUSH : S_SCAN;
          else
            state_nxt = S_IDLE;
        end
      end
      S_PUSH: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    e_kind = KIND_REPLY;
    e_handle = '0;
    e_status = ST_OK;
    e_last = 1'b1;
    if (state_r == S_PUSH) begin
      emit = out_free;
      e_kind = KIND_EXPIRY;
      e_handle = pend_hnd_r;
    end else if (apply) begin
      unique case (item_r.op)
        OP_ALLOC: begin
          emit = 1'b1;
          if (found_r) e_handle = next_handle;
          else e_status = ST_FULL;
        end
        OP_START, OP_STOP, OP_FREE, OP_UPDATE: begin
          emit = 1'b1;
          e_status = reply_status;
        end
        OP_TICK: begin
          emit = pend_v_r;
          e_kind = KIND_EXPIRY;
          e_handle = pend_hnd_r;
          e_last = !found_r;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (emit) begin
      ov_r <= 1'b1;
      okind_r <= e_kind;
      ohandle_r <= e_handle;
      ostatus_r <= e_status;
      olast_r <= e_last;
    end else if (out_tready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r <= '0;
      running_r <= '0;
      fired_r <= '0;
      last_handle_r <= '0;
      order_counter_r <= '0;
      idx_r <= '0;
      found_r <= 1'b0;
      best_r <= '0;
      nev_r <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            item_r.op <= in_tdata[2:0];
            item_r.handle <= in_tdata[34:3];
            item_r.tmo_ms <= in_tdata[66:35];
            item_r.periodic <= in_tdata[67];
            item_r.run_at_once <= in_tdata[68];
            item_r.now_us <= in_tdata[116:69];
            idx_r <= '0;
            found_r <= 1'b0;
            fired_r <= '0;
            nev_r <= '0;
            pend_v_r <= 1'b0;
          end
        end
        S_SCAN: begin
          if (cand && better) begin
            found_r <= 1'b1;
            best_r <= idx_r;
            best_dl_r <= deadline_a_r[idx_r];
            best_ord_r <= order_a_r[idx_r];
          end
          idx_r <= idx_r + SLOT_W'(1);
        end
        S_MUL: begin
          delay_r <= DL_W'(42'(timeout_a_r[best_r]) * 42'(US_PER_MS));
        end
        S_EXEC: begin
          if (out_free) begin
            unique case (item_r.op)
              OP_ALLOC: begin
                if (found_r) begin
                  used_r[best_r] <= 1'b1;
                  running_r[best_r] <= 1'b0;
                  handle_a_r[best_r] <= next_handle;
                  last_handle_r <= next_handle;
                  timeout_a_r[best_r] <= item_r.tmo_ms;
                  periodic_r[best_r] <= item_r.periodic;
                  immediate_r[best_r] <= item_r.run_at_once;
                end
              end
              OP_START: begin
                if (reply_status == ST_OK) begin
                  deadline_a_r[best_r] <= {2'b00, item_r.now_us} +
                                          (immediate_r[best_r] ? '0 : delay_r);
                  order_a_r[best_r] <= order_counter_r;
                  order_counter_r <= order_counter_r + 32'd1;
                  running_r[best_r] <= 1'b1;
                end
              end
              OP_STOP: if (reply_status == ST_OK) running_r[best_r] <= 1'b0;
              OP_FREE: if (reply_status == ST_OK) used_r[best_r] <= 1'b0;
              OP_UPDATE: if (reply_status == ST_OK) timeout_a_r[best_r] <= item_r.tmo_ms;
              OP_TICK: begin
                if (found_r) begin
                  fired_r[best_r] <= 1'b1;
                  pend_hnd_r <= handle_a_r[best_r];
                  pend_v_r <= 1'b1;
                  nev_r <= nev_r + EV_W'(1);
                  idx_r <= '0;
                  found_r <= 1'b0;
                  if (periodic_r[best_r]) begin
                    deadline_a_r[best_r] <= {2'b00, item_r.now_us} + delay_r;
                    order_a_r[best_r] <= order_counter_r;
                    order_counter_r <= order_counter_r + 32'd1;
                  end else begin
                    running_r[best_r] <= 1'b0;
                  end
                end else begin
                  pend_v_r <= 1'b0;
                end
              end
              default: ;
            endcase
          end
        end
        S_PUSH: if (out_free) pend_v_r <= 1'b0;
        default: ;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("accept while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> $stable({out_tuser, out_tlast, out_tdata}))
    else $error("result changed while waiting");
  a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_REPLY) |-> out_tlast) else $error("reply without last");
endmodule

// File: test/sorted_timer_list_engine_tb.sv
// Self-checking testbench for the sorted timer list engine: directed and random commands and ticks.
`timescale 1ns / 1ps
module sorted_timer_list_engine_tb;
  import stle_pkg::*;

  typedef struct {
    logic        kind;
    logic [31:0] hnd;
    logic [1:0]  status;
    logic        last;
  } timer_result_t;

  class timer_scoreboard;
    bit          used [SLOTS];
    bit          running [SLOTS];
    bit [31:0]   hnd [SLOTS];
    bit [31:0]   tmo [SLOTS];
    bit          per [SLOTS];
    bit          imm [SLOTS];
    bit [49:0]   dline [SLOTS];
    bit [31:0]   order [SLOTS];
    bit [31:0]   last_hnd;
    bit [31:0]   order_cnt;
    timer_result_t pending[$];
    int          errors;

    function void push(logic kind, logic [31:0] h, logic [1:0] st, logic last);
      timer_result_t r;
      r.kind = kind; r.hnd = h; r.status = st; r.last = last;
      pending = {pending, r};
    endfunction

    function int lookup(logic [31:0] h);
      for (int i = 0; i < SLOTS; i++)
        if (used[i] && hnd[i] == h) return i;
      return -1;
    endfunction

    function void arm(int i, bit [49:0] delay, bit [47:0] now);
      dline[i] = {2'b00, now} + delay;
      order[i] = order_cnt;
      order_cnt++;
      running[i] = 1;
    endfunction

    function void note_item(item_t it);
      int s, n, best;
      bit fired [SLOTS];
      logic [1:0] st;
      if (it.op == OP_ALLOC) begin
        s = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
        if (s < 0) push(KIND_REPLY, 0, ST_FULL, 1);
        else begin
          last_hnd++;
          if (last_hnd == 0) last_hnd = 1;
          used[s] = 1; running[s] = 0; hnd[s] = last_hnd;
          tmo[s] = it.tmo_ms; per[s] = it.periodic; imm[s] = it.run_at_once;
          push(KIND_REPLY, last_hnd, ST_OK, 1);
        end
      end else if (it.op >= OP_START && it.op <= OP_UPDATE) begin
        st = ST_OK;
        s = lookup(it.handle);
        if (s < 0) st = ST_NOT_FOUND;
        else if (it.op == OP_START) begin
          if (running[s]) st = ST_NOT_FOUND;
          else arm(s, imm[s] ? 50'd0 : 50'(tmo[s]) * 50'd1000, it.now_us);
        end else if (it.op == OP_STOP) begin
          if (!running[s]) st = ST_IDLE; else running[s] = 0;
        end else if (it.op == OP_FREE) begin
          if (running[s]) st = ST_NOT_FOUND; else used[s] = 0;
        end else begin
          if (running[s]) st = ST_NOT_FOUND; else tmo[s] = it.tmo_ms;
        end
        push(KIND_REPLY, 0, st, 1);
      end else if (it.op == OP_TICK) begin
        n = 0;
        foreach (fired[i]) fired[i] = 0;
        while (n < MAX_EVENTS) begin
          best = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!used[i] || !running[i] || fired[i]) continue;
            if (dline[i] > {2'b00, it.now_us}) continue;
            if (best < 0 || dline[i] < dline[best] ||
                (dline[i] == dline[best] && order[i] < order[best])) best = i;
          end
          if (best < 0) break;
          fired[best] = 1;
          push(KIND_EXPIRY, hnd[best], ST_OK, 0);
          n++;
          if (per[best]) arm(best, 50'(tmo[best]) * 50'd1000, it.now_us);
          else running[best] = 0;
        end
        if (n > 0) pending[$].last = 1;
      end
    endfunction

    function void check(timer_result_t got);
      timer_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind=%0d handle=%0h status=%0d last=%0d",
                 $realtime, got.kind, got.hnd, got.status, got.last);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.kind !== got.kind) begin
        $display("%0t: kind expected %0d actual %0d", $realtime, e.kind, got.kind); errors++;
      end
      if (e.hnd !== got.hnd) begin
        $display("%0t: handle expected %0h actual %0h", $realtime, e.hnd, got.hnd); errors++;
      end
      if (e.status !== got.status) begin
        $display("%0t: status expected %0d actual %0d", $realtime, e.status, got.status);
        errors++;
      end
      if (e.last !== got.last) begin
        $display("%0t: last expected %0d actual %0d", $realtime, e.last, got.last); errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [119:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [39:0]  out_tdata;
  logic         out_tuser;
  logic         out_tlast;

  timer_scoreboard sb = new();
  bit [47:0] now_clock;
  bit        rx_hold;
  int        idle_cycles = 0;
  logic [31:0] known_hnd[$];

  sorted_timer_list_engine uut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 80);
    if ($urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 3);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      timer_result_t r;
      r.kind = out_tuser; r.hnd = out_tdata[31:0]; r.status = out_tdata[33:32];
      r.last = out_tlast;
      sb.check(r);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int g;
    @(posedge clk);
    while (1) begin
      if (rx_hold) begin
        out_tready <= 0;
        repeat (400) @(posedge clk);
        rx_hold = 0;
      end
      g = gap_len();
      if (g > 0) begin
        out_tready <= 0;
        repeat (g) @(posedge clk);
      end
      out_tready <= 1;
      @(posedge clk);
    end
  end

  task automatic send_item(item_t it);
    in_tdata  <= {3'b000, it.now_us, it.run_at_once, it.periodic, it.tmo_ms,
                  it.handle, it.op};
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(it);
    if (it.op == OP_ALLOC && sb.pending[$].hnd != 0) known_hnd = {known_hnd, sb.pending[$].hnd};
  endtask

  task automatic send_gap();
    int g;
    g = gap_len();
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic issue(logic [2:0] op, logic [31:0] h, logic [31:0] t, bit p, bit ra,
                       bit [47:0] now);
    item_t it;
    it.op = op; it.handle = h; it.tmo_ms = t; it.periodic = p; it.run_at_once = ra;
    it.now_us = now;
    send_item(it);
  endtask

  function automatic logic [31:0] pick_handle();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0 || known_hnd.size() == 0) return $urandom;
    return known_hnd[$urandom_range(0, known_hnd.size() - 1)];
  endfunction

  initial begin
    int n;
    item_t it;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: fill the table, overflow, start/stop/free/update corners, ticks.
    for (int i = 0; i < 16; i++)
      issue(OP_ALLOC, 0, (i == 0) ? 32'hFFFF_FFFF : i % 3, i[0], i[1], 0);
    issue(OP_ALLOC, 0, 5, 0, 0, 0);
    issue(OP_START, 1, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    issue(OP_START, 1, 0, 0, 0, 0);
    issue(OP_STOP, 1, 0, 0, 0, 0);
    issue(OP_STOP, 1, 0, 0, 0, 0);
    issue(OP_STOP, 32'hFFFF_FFFF, 0, 0, 0, 0);
    issue(OP_UPDATE, 2, 32'hFFFF_FFFF, 0, 0, 0);
    issue(OP_FREE, 3, 0, 0, 0, 0);
    issue(OP_FREE, 3, 0, 0, 0, 0);
    for (int i = 2; i <= 16; i++) issue(OP_START, i, 0, 0, 0, 100);
    issue(OP_TICK, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    issue(OP_TICK, 0, 0, 0, 0, 48'hFFFF_FFFF_FFFF);
    issue(3'd6, 0, 0, 0, 0, 0);
    issue(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1, 48'hFFFF_FFFF_FFFF);
    in_tvalid <= 0;
    now_clock = 200;

    // Sender pause until everything drained.
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);

    n = 0;
    while (n < 400) begin
      if (n == 150) rx_hold = 1;
      if (n == 300) begin
        in_tvalid <= 0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (600) @(posedge clk);
      end
      now_clock += $urandom_range(0, 4000);
      if ($urandom_range(0, 49) == 0) now_clock = 48'({$urandom, $urandom});
      it.now_us = now_clock;
      it.handle = pick_handle();
      it.tmo_ms = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 4);
      it.periodic = $urandom;
      it.run_at_once = $urandom;
      case ($urandom_range(0, 11))
        0, 1:    it.op = OP_ALLOC;
        2, 3, 4: it.op = OP_START;
        5:       it.op = OP_STOP;
        6:       it.op = OP_FREE;
        7:       it.op = OP_UPDATE;
        8:       it.op = 3'($urandom_range(6, 7));
        default: it.op = OP_TICK;
      endcase
      if ($urandom_range(0, 3) == 0 && n < 150) begin
        send_item(it);
      end else begin
        send_gap();
        send_item(it);
      end
      n++;
    end
    in_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
